### rtl/fcd_pkg.sv
// fcd_pkg: shared constants, register indexes and the pixel-stage item struct
// for the frame change detector. No dependencies.
package fcd_pkg;

  localparam int MAX_PIXELS_DEF = 262144;

  localparam int GRAY_W   = 8;
  localparam int PPM_W    = 20;
  localparam int STABLE_W = 16;
  localparam int CHG_W    = 19;

  // bgr to gray, rounded fixed point
  localparam int GRAY_SUM_W = 23;
  localparam int GRAY_SHIFT = 14;
  localparam int COEF_B     = 1868;
  localparam int COEF_G     = 9617;
  localparam int COEF_R     = 4899;
  localparam int GRAY_ROUND = 8192;

  localparam int PPM_SCALE = 1000000;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_PPM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR     = 2'd2;

  localparam logic [GRAY_W-1:0] THRESHOLD_RST = 8'd8;
  localparam logic [PPM_W-1:0]  RATIO_PPM_RST = 20'd2000;
  localparam logic              COLOR_RST     = 1'b1;

  // item leaving the pixel pipeline toward the frame decision
  typedef struct packed {
    logic valid;  // slot holds an item
    logic clr;    // reset-reference command item
    logic pix;    // pixel item
    logic over;   // pixel differs by more than the threshold
    logic last;   // last pixel of a frame
    logic res;    // frame end of a checked frame, gives a result
    logic comp;   // frame is comparable with the reference
  } fcd_px_t;

endpackage

### rtl/fcd_ram.sv
// fcd_ram: generic single-clock ram, one write port and one registered read port.
// No dependencies.
module fcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read returns the old word on a same-address write
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/fcd_pixel.sv
// fcd_pixel: frame tracking, gray conversion, reference ram access and per-pixel
// compare. Uses fcd_pkg and fcd_ram.
module fcd_pixel #(
  parameter int MAX_PIXELS = fcd_pkg::MAX_PIXELS_DEF,
  localparam int IDX_W = $clog2(MAX_PIXELS + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic                        in_func,
  input  logic [fcd_pkg::GRAY_W-1:0]  in_blue,
  input  logic [fcd_pkg::GRAY_W-1:0]  in_green,
  input  logic [fcd_pkg::GRAY_W-1:0]  in_red,
  input  logic                        in_last,
  input  logic                        in_check,
  input  logic                        in_store,
  input  logic                        in_force,
  input  logic [fcd_pkg::GRAY_W-1:0]  thr,
  input  logic                        color,
  output fcd_pkg::fcd_px_t            px,
  output logic [IDX_W-1:0]            px_total
);
  import fcd_pkg::*;

  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

  logic fire;

  // frame state
  logic [IDX_W-1:0] pix_idx_r, pix_idx_nxt;
  logic             ovf_r, ovf_nxt;
  logic             lat_chk_r, lat_chk_nxt;
  logic             lat_st_r, lat_st_nxt;
  logic             lat_frc_r, lat_frc_nxt;
  logic             ref_valid_r, ref_valid_nxt;
  logic [IDX_W-1:0] ref_cnt_r, ref_cnt_nxt;

  logic             first, chk, st, frc, in_range, ovf_now, cmp_en, wr_en0, comp0;
  logic [IDX_W-1:0] idx_inc, total0;
  logic [GRAY_SUM_W-1:0] gray_sum;
  logic [GRAY_W-1:0]     gray0;

  // stage 1
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_clr_r, s1_pix_r, s1_cmp_r, s1_wr_r, s1_last_r, s1_res_r, s1_comp_r;
  logic [IDX_W-1:0] s1_total_r;
  logic [AW-1:0]    s1_addr_r;
  logic [GRAY_W-1:0] s1_gray_r;
  logic             fwd_r;
  logic [GRAY_W-1:0] fwd_data_r;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [GRAY_W-1:0] ram_rdata, ref_pix, diff;
  logic              over1;

  // stage 2
  fcd_px_t          px_r, px_nxt;
  logic [IDX_W-1:0] total2_r;

  assign fire = in_valid && en;

  always_comb begin
    first    = (pix_idx_r == '0) && !ovf_r;
    chk      = first ? in_check : lat_chk_r;
    st       = first ? in_store : lat_st_r;
    frc      = first ? in_force : lat_frc_r;
    in_range = pix_idx_r < IDX_W'(MAX_PIXELS);
    idx_inc  = pix_idx_r + 1'b1;
    ovf_now  = ovf_r || !in_range;
    total0   = ovf_now ? '0 : idx_inc;
    cmp_en   = !in_func && in_range && chk && ref_valid_r && (pix_idx_r < ref_cnt_r);
    wr_en0   = !in_func && in_range && st;
    comp0    = !frc && !ovf_now && ref_valid_r && (total0 == ref_cnt_r) && (total0 != '0);
  end

  always_comb begin
    gray_sum = GRAY_SUM_W'(in_blue)  * GRAY_SUM_W'(COEF_B)
             + GRAY_SUM_W'(in_green) * GRAY_SUM_W'(COEF_G)
             + GRAY_SUM_W'(in_red)   * GRAY_SUM_W'(COEF_R)
             + GRAY_SUM_W'(GRAY_ROUND);
    gray0 = color ? gray_sum[GRAY_SHIFT +: GRAY_W] : in_blue;
  end

  always_comb begin
    pix_idx_nxt   = pix_idx_r;
    ovf_nxt       = ovf_r;
    lat_chk_nxt   = lat_chk_r;
    lat_st_nxt    = lat_st_r;
    lat_frc_nxt   = lat_frc_r;
    ref_valid_nxt = ref_valid_r;
    ref_cnt_nxt   = ref_cnt_r;
    if (fire) begin
      if (in_func) begin
        ref_valid_nxt = 1'b0;
      end else begin
        if (first) begin
          lat_chk_nxt = in_check;
          lat_st_nxt  = in_store;
          lat_frc_nxt = in_force;
        end
        if (in_last) begin
          pix_idx_nxt = '0;
          ovf_nxt     = 1'b0;
          if (st) begin
            ref_valid_nxt = !ovf_now;
            if (!ovf_now) begin
              ref_cnt_nxt = total0;
            end
          end
        end else begin
          if (in_range) begin
            pix_idx_nxt = idx_inc;
          end
          ovf_nxt = ovf_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_idx_r   <= '0;
      ovf_r       <= 1'b0;
      lat_chk_r   <= 1'b0;
      lat_st_r    <= 1'b0;
      lat_frc_r   <= 1'b0;
      ref_valid_r <= 1'b0;
      ref_cnt_r   <= '0;
    end else begin
      pix_idx_r   <= pix_idx_nxt;
      ovf_r       <= ovf_nxt;
      lat_chk_r   <= lat_chk_nxt;
      lat_st_r    <= lat_st_nxt;
      lat_frc_r   <= lat_frc_nxt;
      ref_valid_r <= ref_valid_nxt;
      ref_cnt_r   <= ref_cnt_nxt;
    end
  end

  // reference memory: read at accept, written back from the stage 1 registers
  assign ram_re    = fire && cmp_en;
  assign ram_raddr = pix_idx_r[AW-1:0];
  assign ram_we    = s1_valid_r && s1_wr_r && en;

  fcd_ram #(
    .WIDTH (GRAY_W),
    .DEPTH (MAX_PIXELS)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr_r),
    .wdata (s1_gray_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s1_valid_nxt = en ? fire : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_clr_r   <= in_func;
      s1_pix_r   <= !in_func;
      s1_cmp_r   <= cmp_en;
      s1_wr_r    <= wr_en0;
      s1_last_r  <= in_last;
      s1_res_r   <= !in_func && in_last && chk;
      s1_comp_r  <= comp0;
      s1_total_r <= total0;
      s1_addr_r  <= pix_idx_r[AW-1:0];
      s1_gray_r  <= gray0;
      // one-pixel frames back to back hit the same entry in the same cycle
      fwd_r      <= ram_we && (s1_addr_r == ram_raddr);
      fwd_data_r <= s1_gray_r;
    end
  end

  always_comb begin
    ref_pix = fwd_r ? fwd_data_r : ram_rdata;
    diff    = (s1_gray_r > ref_pix) ? (s1_gray_r - ref_pix) : (ref_pix - s1_gray_r);
    over1   = s1_cmp_r && (diff > thr);
  end

  always_comb begin
    px_nxt = px_r;
    if (en) begin
      px_nxt.valid = s1_valid_r;
      px_nxt.clr   = s1_clr_r;
      px_nxt.pix   = s1_pix_r;
      px_nxt.over  = over1;
      px_nxt.last  = s1_last_r;
      px_nxt.res   = s1_res_r;
      px_nxt.comp  = s1_comp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0;
    end else begin
      px_r <= px_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      total2_r <= s1_total_r;
    end
  end

  assign px       = px_r;
  assign px_total = total2_r;

endmodule

### rtl/fcd_judge.sv
// fcd_judge: changed-pixel accumulation, ratio test, stable counter and the
// result register. Uses fcd_pkg.
module fcd_judge #(
  parameter int MAX_PIXELS = fcd_pkg::MAX_PIXELS_DEF,
  localparam int IDX_W = $clog2(MAX_PIXELS + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fcd_pkg::fcd_px_t              px,
  input  logic [IDX_W-1:0]              px_total,
  input  logic [fcd_pkg::PPM_W-1:0]     ppm,
  output logic                          en,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_similar,
  output logic [fcd_pkg::STABLE_W-1:0]  out_stable,
  output logic [fcd_pkg::CHG_W-1:0]     out_changed
);
  import fcd_pkg::*;

  localparam int PROD_W = IDX_W + PPM_W;

  logic [IDX_W-1:0] cnt_r, cnt_nxt, sum;

  logic             s3_valid_r, s3_valid_nxt;
  logic             s3_clr_r, s3_res_r, s3_comp_r;
  logic [IDX_W-1:0] s3_cnt_r, s3_total_r;

  logic              s4_valid_r, s4_valid_nxt;
  logic              s4_clr_r, s4_res_r, s4_comp_r;
  logic [IDX_W-1:0]  s4_cnt_r;
  logic [PROD_W-1:0] s4_pchg_r, s4_plim_r;

  logic                similar;
  logic [STABLE_W-1:0] stable_r, stable_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_similar_r;
  logic [STABLE_W-1:0] out_stable_r;
  logic [CHG_W-1:0]    out_changed_r;

  // the pipeline only waits when a result meets a full output register
  assign en = !(s4_valid_r && s4_res_r && out_valid_r && !out_ready);

  assign sum = cnt_r + IDX_W'(px.over);

  always_comb begin
    cnt_nxt = cnt_r;
    if (en && px.valid && px.pix) begin
      cnt_nxt = px.last ? '0 : sum;
    end
  end

  assign s3_valid_nxt = en ? (px.valid && (px.clr || px.res)) : s3_valid_r;
  assign s4_valid_nxt = en ? s3_valid_r : s4_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      s3_valid_r <= s3_valid_nxt;
      s4_valid_r <= s4_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_clr_r   <= px.clr;
      s3_res_r   <= px.res;
      s3_comp_r  <= px.comp;
      s3_cnt_r   <= sum;
      s3_total_r <= px_total;
      s4_clr_r   <= s3_clr_r;
      s4_res_r   <= s3_res_r;
      s4_comp_r  <= s3_comp_r;
      s4_cnt_r   <= s3_cnt_r;
      s4_pchg_r  <= PROD_W'(s3_cnt_r) * PROD_W'(PPM_SCALE);
      s4_plim_r  <= PROD_W'(ppm) * PROD_W'(s3_total_r);
    end
  end

  assign similar = s4_comp_r && (s4_pchg_r < s4_plim_r);

  always_comb begin
    stable_nxt = stable_r;
    if (en && s4_valid_r) begin
      if (s4_clr_r) begin
        stable_nxt = '0;
      end else if (s4_res_r) begin
        if (!similar) begin
          stable_nxt = '0;
        end else if (stable_r != '1) begin
          stable_nxt = stable_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (en && s4_valid_r && s4_res_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      stable_r    <= stable_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s4_valid_r && s4_res_r) begin
      out_similar_r <= similar;
      out_stable_r  <= stable_nxt;
      out_changed_r <= s4_comp_r ? CHG_W'(s4_cnt_r) : '0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_similar = out_similar_r;
  assign out_stable  = out_stable_r;
  assign out_changed = out_changed_r;

endmodule

### rtl/frame_change_detector_unit.sv
// frame_change_detector_unit: top level with the configuration registers and
// the stream ports. Uses fcd_pkg, fcd_pixel, fcd_judge (and fcd_ram below).
//
// Frames stream in on the in_ channel, one pixel item per accepted cycle, with
// in_tlast on the last pixel. in_tuser high makes the item a command that
// drops the reference and clears the stable counter; it gives no result.
// Each pixel is converted to gray, compared with the reference memory entry
// at its position and, for store frames, written back over it from the stage 1
// registers. A checked frame presents one result item on the out_ channel once
// its last pixel has passed the stage 1, stage 2, s3, s4 and output registers.
// Throughput is one item per cycle when not stalled, bounded by the single
// read and single write of the reference ram per pixel. in_tready drops only
// while a new result reaches the end of the pipeline and the output register
// still holds an item the receiver has not taken; pixels flow on otherwise.
// Reset clears the reference valid flag, its pixel count, the frame position
// and the stable counter, and loads the register reset values. The reference
// memory itself is not cleared: no entry is read until a stored frame wrote it.
// Config writes on cfg_ take effect at once and are meant for idle periods.
module frame_change_detector_unit #(
  parameter int MAX_PIXELS = fcd_pkg::MAX_PIXELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // blue_or_gray[7:0], green[15:8], red[23:16], check_frame[24],
  // store_frame[25], force_frame[26], zero pad[31:27]
  input  logic [31:0]                     in_tdata,
  // func: 0 pixel, 1 reset reference and counter
  input  logic                            in_tuser,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // similar[0], stable_frames[16:1], changed_pixels[35:17], zero pad[39:36]
  output logic [39:0]                     out_tdata,
  input  logic                            cfg_we,
  input  logic [fcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fcd_pkg::PPM_W-1:0]       cfg_wdata
);
  import fcd_pkg::*;

  localparam int IDX_W = $clog2(MAX_PIXELS + 1);

  logic [GRAY_W-1:0] thr_r, thr_nxt;
  logic [PPM_W-1:0]  ppm_r, ppm_nxt;
  logic              color_r, color_nxt;

  fcd_px_t             px;
  logic [IDX_W-1:0]    px_total;
  logic                en;
  logic                similar;
  logic [STABLE_W-1:0] stable;
  logic [CHG_W-1:0]    changed;

  always_comb begin
    thr_nxt   = thr_r;
    ppm_nxt   = ppm_r;
    color_nxt = color_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD: thr_nxt   = cfg_wdata[GRAY_W-1:0];
        CFG_RATIO_PPM: ppm_nxt   = cfg_wdata;
        CFG_COLOR:     color_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= THRESHOLD_RST;
      ppm_r   <= RATIO_PPM_RST;
      color_r <= COLOR_RST;
    end else begin
      thr_r   <= thr_nxt;
      ppm_r   <= ppm_nxt;
      color_r <= color_nxt;
    end
  end

  fcd_pixel #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_pixel (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .in_func  (in_tuser),
    .in_blue  (in_tdata[7:0]),
    .in_green (in_tdata[15:8]),
    .in_red   (in_tdata[23:16]),
    .in_last  (in_tlast),
    .in_check (in_tdata[24]),
    .in_store (in_tdata[25]),
    .in_force (in_tdata[26]),
    .thr      (thr_r),
    .color    (color_r),
    .px       (px),
    .px_total (px_total)
  );

  fcd_judge #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_judge (
    .clk         (clk),
    .rst_n       (rst_n),
    .px          (px),
    .px_total    (px_total),
    .ppm         (ppm_r),
    .en          (en),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_similar (similar),
    .out_stable  (stable),
    .out_changed (changed)
  );

  assign in_tready = en;
  assign out_tdata = {4'd0, changed, stable, similar};

`ifndef SYNTHESIS
  // input stalls only behind a result the receiver has not taken
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output backpressure");

  a_similar_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> (out_tdata[16:1] != 16'd0))
    else $error("similar result with zero stable count");

  a_change_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[16:1] == 16'd0))
    else $error("changed result without stable count clear");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");
`endif

endmodule
